[rtl/vertex_transform_project_top_macros.svh]
// Assertion macros shared by the vertex transform RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef VERTEX_TRANSFORM_PROJECT_TOP_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define VTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define VTP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/vtp_pkg.sv]
// Package for the vertex transform block: payload structs, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package vtp_pkg;

  localparam int IO_WIDTH      = 32;
  localparam int ROW_WIDTH     = 64;
  localparam int LANE_WIDTH    = 16;
  localparam int NUM_ROWS      = 4;
  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ROW0    = 3'd0,
    CFG_ROW1    = 3'd1,
    CFG_ROW2    = 3'd2,
    CFG_ROW3    = 3'd3,
    CFG_PROJECT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] vin_x;
    logic signed [IO_WIDTH-1:0] vin_y;
    logic signed [IO_WIDTH-1:0] vin_z;
    logic signed [IO_WIDTH-1:0] vin_w;
  } vin_t;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] vout_x;
    logic signed [IO_WIDTH-1:0] vout_y;
    logic signed [IO_WIDTH-1:0] vout_z;
    logic signed [IO_WIDTH-1:0] vout_w;
    logic                       w_was_zero;
    logic                       saturated;
  } vout_t;

  typedef logic [ROW_WIDTH-1:0] row_t;

endpackage

[rtl/vtp_front.sv]
// Front end: matrix multiply in two stages (products, then sum/shift/clamp).
// Depends on vtp_pkg.
`timescale 1ns / 1ps

module vtp_front import vtp_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int COMP_WIDTH = 32,
  localparam int EW = 4 * COMP_WIDTH + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  vin_t          vin_i,
  input  logic          proj_i,
  input  row_t          rows_i [NUM_ROWS],
  output logic          ent_valid_o,
  output logic [EW-1:0] ent_o,
  output logic [1:0]    inflight_o
);

  localparam int PW   = COMP_WIDTH + COEF_WIDTH;
  localparam int SW   = PW + 2;
  localparam int FRAC = COEF_WIDTH - 4;
  localparam longint CMAX_L = (longint'(1) << (COMP_WIDTH - 1)) - 1;
  localparam logic signed [SW-1:0] CMAX = SW'(CMAX_L);
  localparam logic signed [SW-1:0] CMIN = SW'(-CMAX_L - 1);

  logic signed [COMP_WIDTH-1:0] comp [4];
  logic signed [COEF_WIDTH-1:0] coef [NUM_ROWS][4];
  logic signed [PW-1:0]         prod_d [NUM_ROWS][4];
  logic signed [PW-1:0]         prod_q [NUM_ROWS][4];
  logic                         s1_valid_q, s2_valid_q, s1_proj_q;
  logic signed [SW-1:0]         sum [NUM_ROWS];
  logic signed [SW-1:0]         shf [NUM_ROWS];
  logic [COMP_WIDTH-1:0]        res [NUM_ROWS];
  logic [NUM_ROWS-1:0]          clip;
  logic [EW-1:0]                ent_d, ent_q;

  always_comb begin
    comp[0] = vin_i.vin_x[COMP_WIDTH-1:0];
    comp[1] = vin_i.vin_y[COMP_WIDTH-1:0];
    comp[2] = vin_i.vin_z[COMP_WIDTH-1:0];
    comp[3] = vin_i.vin_w[COMP_WIDTH-1:0];
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int j = 0; j < 4; j++) begin
        coef[r][j]   = rows_i[r][LANE_WIDTH*j +: COEF_WIDTH];
        prod_d[r][j] = PW'(comp[j]) * PW'(coef[r][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    s1_proj_q <= proj_i;
    ent_q     <= ent_d;
  end

  // Sum the row, drop the coefficient fraction bits, clamp to the component range.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum[r] = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2]) + SW'(prod_q[r][3]);
      shf[r] = sum[r] >>> FRAC;
      clip[r] = 1'b0;
      if (shf[r] > CMAX) begin
        res[r]  = CMAX[COMP_WIDTH-1:0];
        clip[r] = 1'b1;
      end else if (shf[r] < CMIN) begin
        res[r]  = CMIN[COMP_WIDTH-1:0];
        clip[r] = 1'b1;
      end else begin
        res[r] = shf[r][COMP_WIDTH-1:0];
      end
    end
    ent_d = {s1_proj_q, |clip, res[3], res[2], res[1], res[0]};
  end

  assign ent_valid_o = s2_valid_q;
  assign ent_o       = ent_q;
  assign inflight_o  = 2'(s1_valid_q) + 2'(s2_valid_q);

endmodule

[rtl/vtp_queue.sv]
// Small register queue between the front and back ends.
// Depends on vtp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_transform_project_top_macros.svh"

module vtp_queue import vtp_pkg::*; #(
  parameter int WIDTH = 130,
  parameter int DEPTH = 4,
  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CNTW-1:0]  count_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_q, rd_q;
  logic [CNTW-1:0]  count_q;
  logic             full;

  assign full    = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `VTP_NEVER(a_no_overflow, push_i && full && !pop_i, "queue overflow")
  `VTP_NEVER(a_no_underflow, pop_i && empty_o, "queue underflow")
  `VTP_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1, "count slip")

endmodule

[rtl/vtp_back.sv]
// Back end: perspective divide as a bit-per-stage restoring divider pipeline
// for x, y, z, then sign, clamp and the output register. Depends on vtp_pkg.
`timescale 1ns / 1ps

module vtp_back import vtp_pkg::*; #(
  parameter int COMP_WIDTH = 32,
  localparam int EW = 4 * COMP_WIDTH + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [EW-1:0] ent_i,
  output logic          pop_o,
  input  logic          stall_i,
  output logic          valid_o,
  output vout_t         vout_o
);

  localparam int CW   = COMP_WIDTH;
  localparam int FRAC = COMP_WIDTH / 2;
  localparam int NW   = CW + FRAC;
  localparam longint CMAX_L = (longint'(1) << (CW - 1)) - 1;
  localparam logic [NW-1:0] QMAX = NW'(CMAX_L);
  localparam logic [NW-1:0] QMIN = NW'(CMAX_L + 1);

  logic en;

  // Per-stage registers; stage 0 holds the prepared operands.
  logic              v_q    [NW+1];
  logic [CW-1:0]     rem_q  [NW+1][3];
  logic [NW-1:0]     nq_q   [NW+1][3];
  logic [CW-1:0]     orig_q [NW+1][4];
  logic [CW-1:0]     d_q    [NW+1];
  logic [2:0]        neg_q  [NW+1];
  logic              div_q  [NW+1];
  logic              wz_q   [NW+1];
  logic              sat_q  [NW+1];

  logic signed [CW-1:0] res [4];
  logic [CW-1:0]        mag [3];
  logic                 proj, wzero;

  logic    out_valid_q;
  vout_t   vout_q, vout_d;

  assign en    = !out_valid_q || !stall_i;
  assign pop_o = valid_i && en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = ent_i[CW*i +: CW];
    end
    proj  = ent_i[EW-1];
    wzero = (res[3] == '0);
    for (int i = 0; i < 3; i++) begin
      mag[i] = res[i][CW-1] ? CW'(-res[i]) : CW'(res[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= '0;
        nq_q[0][i]  <= {mag[i], {FRAC{1'b0}}};
        neg_q[0][i] <= res[i][CW-1] ^ res[3][CW-1];
      end
      for (int i = 0; i < 4; i++) begin
        orig_q[0][i] <= res[i];
      end
      d_q[0]   <= res[3][CW-1] ? CW'(-res[3]) : CW'(res[3]);
      div_q[0] <= proj && !wzero;
      wz_q[0]  <= proj && wzero;
      sat_q[0] <= ent_i[EW-2];
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [CW:0]   tmp [3];
    logic [CW:0]   dif [3];
    logic [CW-1:0] rem_d [3];
    logic [2:0]    qb;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tmp[i]   = {rem_q[k-1][i], nq_q[k-1][i][NW-1]};
        dif[i]   = tmp[i] - {1'b0, d_q[k-1]};
        qb[i]    = (tmp[i] >= {1'b0, d_q[k-1]});
        rem_d[i] = qb[i] ? dif[i][CW-1:0] : tmp[i][CW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= rem_d[i];
          nq_q[k][i]  <= {nq_q[k-1][i][NW-2:0], qb[i]};
        end
        orig_q[k] <= orig_q[k-1];
        d_q[k]    <= d_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        div_q[k]  <= div_q[k-1];
        wz_q[k]   <= wz_q[k-1];
        sat_q[k]  <= sat_q[k-1];
      end
    end
  end

  // Apply the sign, clamp the quotient, pick divided or plain components.
  always_comb begin
    logic [CW-1:0] val [3];
    logic [NW-1:0] q;
    logic          clip;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = nq_q[NW][i];
      if (!div_q[NW]) begin
        val[i] = orig_q[NW][i];
      end else if (!neg_q[NW][i] && q > QMAX) begin
        val[i] = QMAX[CW-1:0];
        clip   = 1'b1;
      end else if (neg_q[NW][i] && q > QMIN) begin
        val[i] = QMIN[CW-1:0];
        clip   = 1'b1;
      end else begin
        val[i] = neg_q[NW][i] ? CW'(-q) : q[CW-1:0];
      end
    end
    vout_d.vout_x     = IO_WIDTH'($signed(val[0]));
    vout_d.vout_y     = IO_WIDTH'($signed(val[1]));
    vout_d.vout_z     = IO_WIDTH'($signed(val[2]));
    vout_d.vout_w     = IO_WIDTH'($signed(orig_q[NW][3]));
    vout_d.w_was_zero = wz_q[NW];
    vout_d.saturated  = sat_q[NW] | clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vout_q <= vout_d;
    end
  end

  assign valid_o = out_valid_q;
  assign vout_o  = vout_q;

endmodule

[rtl/vertex_transform_project_top.sv]
// Top level of the vertex transform: configuration registers, front end,
// queue and divide back end. Depends on vtp_pkg and the vtp_* modules.
`timescale 1ns / 1ps

// Vertex transform: each request carries one homogeneous vertex (x, y, z, w,
// signed Q16.16 at the default width) and yields one result: the vertex times
// a 4x4 matrix of signed Q4.12 coefficients, each row sum shifted back to the
// component format and saturated. With projection on and a nonzero w, x, y
// and z are divided by w (truncated toward zero, saturated); w is passed
// undivided, and a zero w skips the divide and raises w_was_zero. The block
// takes one vertex per clock cycle unless stalled; a vertex passes through the
// front-end registers, the queue, the bit-per-stage divider pipeline and the
// output register. The front end computes the products in one stage and the
// row sums in the next and pushes into a four-entry queue; input stall rises
// only when the front end and the queue together hold four vertices. The
// back end pulls from the queue, runs the divider and holds the result in an
// output register, so a stall at the output fills the queue before it
// reaches the input. Matrix rows are written through the configuration port
// (always ready), and the user must do so only while no vertex is in flight;
// the block does not enforce this. Reset: identity matrix, projection on.
module vertex_transform_project_top import vtp_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  vin_t                     vin_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output vout_t                    vout_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [ROW_WIDTH-1:0]     cfg_data_i
);

  localparam int EW          = 4 * COMP_WIDTH + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int CNTW        = $clog2(QUEUE_DEPTH + 1);

  row_t            rows_q [NUM_ROWS];
  logic            proj_q;
  logic            in_accept;
  logic            ent_valid;
  logic [EW-1:0]   ent, q_data;
  logic [1:0]      inflight;
  logic [CNTW-1:0] q_count;
  logic [CNTW-1:0] total;
  logic            q_empty, q_pop;

  // Configuration: always ready; ignore indexes beyond the register list.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_q[r] <= ROW_WIDTH'(1) << (LANE_WIDTH * r + COEF_WIDTH - 4);
      end
      proj_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROW0:    rows_q[0] <= cfg_data_i;
        CFG_ROW1:    rows_q[1] <= cfg_data_i;
        CFG_ROW2:    rows_q[2] <= cfg_data_i;
        CFG_ROW3:    rows_q[3] <= cfg_data_i;
        CFG_PROJECT: proj_q    <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // Credit check: hold the input when every queue slot is spoken for.
  assign total      = CNTW'(inflight) + q_count;
  assign in_stall_o = (total >= CNTW'(QUEUE_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;

  vtp_front #(
    .COEF_WIDTH(COEF_WIDTH),
    .COMP_WIDTH(COMP_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_accept),
    .vin_i      (vin_i),
    .proj_i     (proj_q),
    .rows_i     (rows_q),
    .ent_valid_o(ent_valid),
    .ent_o      (ent),
    .inflight_o (inflight)
  );

  vtp_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ent_valid),
    .data_i (ent),
    .pop_i  (q_pop),
    .data_o (q_data),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  vtp_back #(
    .COMP_WIDTH(COMP_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(!q_empty),
    .ent_i  (q_data),
    .pop_o  (q_pop),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .vout_o (vout_o)
  );

endmodule
